>>> hdl/memory_map_attribute_coalescer_macros.svh
// Assertion helpers for the memory map attribute coalescer.
// Both sample on clk and are disabled while rst_n is low.
`ifndef MEMORY_MAP_ATTRIBUTE_COALESCER_MACROS_SVH
`define MEMORY_MAP_ATTRIBUTE_COALESCER_MACROS_SVH

// Same-cycle implication.
`define MMAC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define MMAC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> hdl/mmac_pkg.sv
package mmac_pkg;

  // One incoming memory map descriptor
  typedef struct packed {
    logic [31:0] mem_type;
    logic [63:0] phys_start;
    logic [63:0] virt_start;
    logic [51:0] page_count;
    logic [63:0] attributes;
    logic        end_of_map;
  } mmac_in_t;

  // One coalesced descriptor
  typedef struct packed {
    logic [31:0] out_type;
    logic [63:0] out_phys_start;
    logic [63:0] out_virt_start;
    logic [51:0] out_pages;
    logic [63:0] out_attributes;
    logic        out_last;
  } mmac_out_t;

  // Configuration register values
  typedef struct packed {
    logic [31:0] code_type;
    logic [63:0] readonly_mask;
    logic [63:0] noexec_mask;
  } mmac_cfg_t;

  // Push controls from the merge core to the result queue
  typedef struct packed {
    logic push0;
    logic push1;
  } mmac_push_t;

  // Register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_TYPE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_READONLY_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOEXEC_MASK   = 2'd2;

  // Register reset values
  localparam logic [31:0] RST_CODE_TYPE     = 32'd5;
  localparam logic [63:0] RST_READONLY_MASK = 64'h0000_0000_0002_0000;
  localparam logic [63:0] RST_NOEXEC_MASK   = 64'h0000_0000_0000_4000;

  localparam logic [51:0] PAGES_MAX = {52{1'b1}};

  // Result queue depth; two slots are reserved per processed item
  localparam int FIFO_DEPTH = 4;

endpackage

>>> hdl/mmac_core.sv
module mmac_core #(
  parameter int PAGE_SHIFT = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  mmac_pkg::mmac_in_t  item,
  input  mmac_pkg::mmac_cfg_t cfg,
  output mmac_pkg::mmac_push_t push,
  output mmac_pkg::mmac_out_t res0,
  output mmac_pkg::mmac_out_t res1
);

  // Pending descriptor
  logic        pend_vld_r, pend_vld_nxt;
  logic [31:0] pend_type_r, pend_type_nxt;
  logic [63:0] pend_phys_r, pend_phys_nxt;
  logic [63:0] pend_virt_r, pend_virt_nxt;
  logic [51:0] pend_pages_r, pend_pages_nxt;
  logic [63:0] pend_attr_r, pend_attr_nxt;

  logic [63:0] attr_fix;
  logic [63:0] pend_end;
  logic [52:0] page_sum;
  logic [51:0] page_sat;
  logic        merge;
  logic        emit_old;
  mmac_pkg::mmac_out_t res_old;
  mmac_pkg::mmac_out_t res_flush;

  // Attribute fixup: zero mask gets read-only for code, no-execute otherwise
  always_comb begin
    if (item.attributes != 64'd0) begin
      attr_fix = item.attributes;
    end else if (item.mem_type == cfg.code_type) begin
      attr_fix = cfg.readonly_mask;
    end else begin
      attr_fix = cfg.noexec_mask;
    end
  end

  // End address of the pending run, wraps at 64 bits
  assign pend_end = pend_phys_r + (64'(pend_pages_r) << PAGE_SHIFT);

  assign merge = pend_vld_r && (item.mem_type == pend_type_r) &&
                 (attr_fix == pend_attr_r) && (pend_end == item.phys_start);
  assign emit_old = pend_vld_r && !merge;

  // Saturating page sum
  assign page_sum = {1'b0, pend_pages_r} + {1'b0, item.page_count};
  assign page_sat = page_sum[52] ? mmac_pkg::PAGES_MAX : page_sum[51:0];

  // Next pending descriptor
  always_comb begin
    pend_vld_nxt   = pend_vld_r;
    pend_type_nxt  = pend_type_r;
    pend_phys_nxt  = pend_phys_r;
    pend_virt_nxt  = pend_virt_r;
    pend_pages_nxt = pend_pages_r;
    pend_attr_nxt  = pend_attr_r;
    if (merge) begin
      pend_pages_nxt = page_sat;
    end else begin
      pend_type_nxt  = item.mem_type;
      pend_phys_nxt  = item.phys_start;
      pend_virt_nxt  = item.virt_start;
      pend_pages_nxt = item.page_count;
      pend_attr_nxt  = attr_fix;
    end
    if (go) begin
      pend_vld_nxt = !item.end_of_map;
    end
  end

  // Result items: displaced run first, then the end-of-map flush
  always_comb begin
    res_old.out_type       = pend_type_r;
    res_old.out_phys_start = pend_phys_r;
    res_old.out_virt_start = pend_virt_r;
    res_old.out_pages      = pend_pages_r;
    res_old.out_attributes = pend_attr_r;
    res_old.out_last       = 1'b0;

    res_flush.out_type       = pend_type_nxt;
    res_flush.out_phys_start = pend_phys_nxt;
    res_flush.out_virt_start = pend_virt_nxt;
    res_flush.out_pages      = pend_pages_nxt;
    res_flush.out_attributes = pend_attr_nxt;
    res_flush.out_last       = 1'b1;
  end

  assign res0       = emit_old ? res_old : res_flush;
  assign res1       = res_flush;
  assign push.push0 = go && (emit_old || item.end_of_map);
  assign push.push1 = go && emit_old && item.end_of_map;

  // Pending registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
    end else begin
      pend_vld_r <= pend_vld_nxt;
    end
    if (go) begin
      pend_type_r  <= pend_type_nxt;
      pend_phys_r  <= pend_phys_nxt;
      pend_virt_r  <= pend_virt_nxt;
      pend_pages_r <= pend_pages_nxt;
      pend_attr_r  <= pend_attr_nxt;
    end
  end

endmodule

>>> hdl/mmac_fifo.sv
module mmac_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mmac_pkg::mmac_push_t push,
  input  mmac_pkg::mmac_out_t  wdata0,
  input  mmac_pkg::mmac_out_t  wdata1,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mmac_pkg::mmac_out_t  out_item
);

  localparam int PTR_W = $clog2(mmac_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(mmac_pkg::FIFO_DEPTH + 1);

  mmac_pkg::mmac_out_t mem [mmac_pkg::FIFO_DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] wr_ptr_p1;
  logic             pop;

  assign pop       = (cnt_r != '0) && !out_stall;
  assign out_valid = (cnt_r != '0);
  assign out_item  = mem[rd_ptr_r];
  // Room for the two items one step can produce
  assign room      = (cnt_r <= CNT_W'(mmac_pkg::FIFO_DEPTH - 2));
  assign wr_ptr_p1 = wr_ptr_r + PTR_W'(1);

  // Pointer and level update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.push0) + PTR_W'(push.push1);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    cnt_nxt    = cnt_r + CNT_W'(push.push0) + CNT_W'(push.push1) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage writes, up to two per cycle
  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[wr_ptr_r] <= wdata0;
    end
    if (push.push1) begin
      mem[wr_ptr_p1] <= wdata1;
    end
  end

endmodule

>>> hdl/memory_map_attribute_coalescer.sv
// Memory map attribute coalescer.
// Input channel (in_valid / in_stall / in_item): one descriptor per item.
// Output channel (out_valid / out_stall / out_item): coalesced descriptors.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_wdata): index 0 is
// the code type, 1 the read-only mask, 2 the no-execute mask; cfg_ready is
// always high and writes are meant for idle periods only.
// A descriptor sits in an input register, then one pass of compare, add and
// saturate updates the pending run and pushes 0, 1 or 2 items into a
// four-entry result queue that drives the output directly.
// Throughput: one item per cycle while out_stall stays low and each item
// produces at most one result; an item producing two results takes the
// queue space of two pops. A run's result is pushed into the result queue
// when the item that ends it (a non-mergeable descriptor or the end-of-map
// mark) leaves the input register. in_stall rises when an item is held in
// the input register because the queue lacks room for two items; a stalled
// receiver fills the queue and back-pressures the input beyond two entries.
// Reset empties the queue, drops any pending run, and restores the
// configuration reset values.
module memory_map_attribute_coalescer #(
  parameter int PAGE_SHIFT = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mmac_pkg::mmac_in_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mmac_pkg::mmac_out_t                 out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mmac_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [63:0]                         cfg_wdata
);

  `include "memory_map_attribute_coalescer_macros.svh"

  mmac_pkg::mmac_in_t   in_item_r;
  logic                 in_vld_r, in_vld_nxt;
  logic                 in_accept;
  logic                 go;
  logic                 room;
  mmac_pkg::mmac_cfg_t  cfg_r;
  mmac_pkg::mmac_push_t push;
  mmac_pkg::mmac_out_t  res0;
  mmac_pkg::mmac_out_t  res1;

  // Input register handshake
  assign go        = in_vld_r && room;
  assign in_stall  = in_vld_r && !go;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_accept) begin
      in_vld_nxt = 1'b1;
    end else if (go) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
    if (in_accept) begin
      in_item_r <= in_item;
    end
  end

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.code_type     <= mmac_pkg::RST_CODE_TYPE;
      cfg_r.readonly_mask <= mmac_pkg::RST_READONLY_MASK;
      cfg_r.noexec_mask   <= mmac_pkg::RST_NOEXEC_MASK;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mmac_pkg::CFG_CODE_TYPE:     cfg_r.code_type     <= cfg_wdata[31:0];
        mmac_pkg::CFG_READONLY_MASK: cfg_r.readonly_mask <= cfg_wdata;
        mmac_pkg::CFG_NOEXEC_MASK:   cfg_r.noexec_mask   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mmac_core #(
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (in_item_r),
    .cfg   (cfg_r),
    .push  (push),
    .res0  (res0),
    .res1  (res1)
  );

  mmac_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wdata0    (res0),
    .wdata1    (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // Checks
  `MMAC_ASSERT_IMPL(a_push_order, push.push1, push.push0)
  `MMAC_ASSERT_IMPL(a_push_on_go, push.push0, go)
  `MMAC_ASSERT_IMPL(a_flush_on_eom, go && in_item_r.end_of_map, push.push0 && res1.out_last)
  `MMAC_ASSERT_NEXT(a_held_item_kept, in_vld_r && !go, in_vld_r && $stable(in_item_r))

endmodule

>>> verif/testbench.sv
module testbench;

  localparam int PAGE_SHIFT = 12;
  localparam int PHASE_ITEMS = 135;
  localparam int NUM_PHASES = 6;
  localparam int BACKLOG_CYCLES = 80;

  // Reference state of the coalescer plus the queue of descriptors it owes
  class merged_map_model;
    logic [31:0] code_ty;
    logic [63:0] ro_mask;
    logic [63:0] nx_mask;
    bit          run_open;
    logic [31:0] run_type;
    logic [63:0] run_phys;
    logic [63:0] run_virt;
    logic [51:0] run_pages;
    logic [63:0] run_attr;
    mmac_pkg::mmac_out_t due_descs[$];
    int errors;
    int n_in;
    int n_out;
    int n_merge;
    int n_sat;
    int n_flush;

    function new();
      code_ty   = mmac_pkg::RST_CODE_TYPE;
      ro_mask   = mmac_pkg::RST_READONLY_MASK;
      nx_mask   = mmac_pkg::RST_NOEXEC_MASK;
      run_open  = 1'b0;
      run_type  = '0;
      run_phys  = '0;
      run_virt  = '0;
      run_pages = '0;
      run_attr  = '0;
    endfunction

    function void set_reg(logic [mmac_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
      case (idx)
        mmac_pkg::CFG_CODE_TYPE:     code_ty = data[31:0];
        mmac_pkg::CFG_READONLY_MASK: ro_mask = data;
        mmac_pkg::CFG_NOEXEC_MASK:   nx_mask = data;
        default: ;
      endcase
    endfunction

    function mmac_pkg::mmac_out_t run_as_result(bit last);
      mmac_pkg::mmac_out_t r;
      r.out_type       = run_type;
      r.out_phys_start = run_phys;
      r.out_virt_start = run_virt;
      r.out_pages      = run_pages;
      r.out_attributes = run_attr;
      r.out_last       = last;
      return r;
    endfunction

    // Fix attributes, then merge into the open run or close it
    function void take_descriptor(mmac_pkg::mmac_in_t d);
      logic [63:0] attr;
      logic [63:0] run_end;
      logic [52:0] sum;
      n_in++;
      attr = d.attributes;
      if (attr == '0) attr = (d.mem_type == code_ty) ? ro_mask : nx_mask;
      run_end = run_phys + (64'(run_pages) << PAGE_SHIFT);
      if (run_open && d.mem_type == run_type && attr == run_attr &&
          run_end == d.phys_start) begin
        sum = {1'b0, run_pages} + {1'b0, d.page_count};
        n_merge++;
        if (sum[52]) begin
          run_pages = mmac_pkg::PAGES_MAX;
          n_sat++;
        end else begin
          run_pages = sum[51:0];
        end
      end else begin
        if (run_open) due_descs.push_back(run_as_result(1'b0));
        run_open  = 1'b1;
        run_type  = d.mem_type;
        run_phys  = d.phys_start;
        run_virt  = d.virt_start;
        run_pages = d.page_count;
        run_attr  = attr;
      end
      // end of map flushes whatever is open
      if (d.end_of_map) begin
        due_descs.push_back(run_as_result(1'b1));
        run_open = 1'b0;
        n_flush++;
      end
    endfunction

    function void cmp(string name, logic [63:0] e, logic [63:0] a);
      if (a !== e) begin
        $error("%s: expected %h, got %h", name, e, a);
        errors++;
      end
    endfunction

    function void check_merged(mmac_pkg::mmac_out_t got);
      mmac_pkg::mmac_out_t exp;
      n_out++;
      if (due_descs.size() == 0) begin
        $error("unexpected descriptor: type %h phys %h pages %h",
               got.out_type, got.out_phys_start, got.out_pages);
        errors++;
        return;
      end
      exp = due_descs.pop_front();
      cmp("out_type", 64'(exp.out_type), 64'(got.out_type));
      cmp("out_phys_start", exp.out_phys_start, got.out_phys_start);
      cmp("out_virt_start", exp.out_virt_start, got.out_virt_start);
      cmp("out_pages", 64'(exp.out_pages), 64'(got.out_pages));
      cmp("out_attributes", exp.out_attributes, got.out_attributes);
      cmp("out_last", 64'(exp.out_last), 64'(got.out_last));
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  mmac_pkg::mmac_in_t             in_item;
  logic                           out_valid;
  logic                           out_stall;
  mmac_pkg::mmac_out_t            out_item;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [mmac_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [63:0]                    cfg_wdata;

  merged_map_model sb = new();

  // current register values, used to steer the generator
  logic [31:0] cur_code = mmac_pkg::RST_CODE_TYPE;
  logic [63:0] cur_ro = mmac_pkg::RST_READONLY_MASK;
  logic [63:0] cur_nx = mmac_pkg::RST_NOEXEC_MASK;
  bit calm = 1'b0;
  bit backlog_req = 1'b0;
  int n_cfg = 0;

  memory_map_attribute_coalescer #(
    .PAGE_SHIFT(PAGE_SHIFT)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watch all three channels at the clock edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.take_descriptor(in_item);
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_wdata);
      if (out_valid && !out_stall) sb.check_merged(out_item);
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (backlog_req) begin
        backlog_req = 1'b0;
        out_stall <= 1'b1;
        repeat (BACKLOG_CYCLES) @(posedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 22);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d descriptors still due", sb.due_descs.size());
    $display("TB_ERROR");
    $finish;
  end

  task automatic drive_item(mmac_pkg::mmac_in_t d);
    while (!calm && $urandom_range(0, 99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= d;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(logic [mmac_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(logic [31:0] ct, logic [63:0] ro, logic [63:0] nx);
    write_reg(mmac_pkg::CFG_CODE_TYPE, 64'(ct));
    write_reg(mmac_pkg::CFG_READONLY_MASK, ro);
    write_reg(mmac_pkg::CFG_NOEXEC_MASK, nx);
    cfg_valid <= 1'b0;
    cur_code = ct;
    cur_ro   = ro;
    cur_nx   = nx;
    n_cfg++;
  endtask

  // Stop offering, drain every owed descriptor, then give the pipe time
  task automatic settle();
    in_valid <= 1'b0;
    // wait for the clock so the last accepted item is already in the scoreboard
    @(posedge clk);
    while (sb.due_descs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic mmac_pkg::mmac_in_t mk(logic [31:0] t, logic [63:0] p, logic [63:0] v,
                                            logic [51:0] n, logic [63:0] a, logic e);
    mmac_pkg::mmac_in_t d;
    d.mem_type   = t;
    d.phys_start = p;
    d.virt_start = v;
    d.page_count = n;
    d.attributes = a;
    d.end_of_map = e;
    return d;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] pick_type();
    case ($urandom_range(0, 4))
      0, 1: return cur_code;
      2: return 32'd7;
      3: return 32'd3;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] pick_attr();
    case ($urandom_range(0, 5))
      0, 1: return '0;
      2: return cur_ro;
      3: return cur_nx;
      4: return 64'h8;
      default: return rand64();
    endcase
  endfunction

  function automatic logic [51:0] pick_pages();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return mmac_pkg::PAGES_MAX - 52'($urandom_range(0, 3));
      2: return 52'(rand64());
      default: return 52'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic logic [63:0] pick_base();
    case ($urandom_range(0, 3))
      0: return rand64() & ~64'hFFF;
      1: return 64'hFFFF_FFFF_FFF0_0000;
      default: return 64'($urandom_range(0, 'hFFFFF)) << PAGE_SHIFT;
    endcase
  endfunction

  // A memory map: runs of contiguous descriptors sharing type and attributes
  task automatic send_map(int len, bit broken);
    mmac_pkg::mmac_in_t d;
    logic [63:0] next_phys;
    logic [31:0] ty;
    logic [63:0] at;
    next_phys = pick_base();
    ty = pick_type();
    at = pick_attr();
    for (int i = 0; i < len; i++) begin
      if (i != 0 && $urandom_range(0, 3) == 0) begin
        ty = pick_type();
        at = pick_attr();
      end
      d.mem_type   = ty;
      d.attributes = at;
      d.phys_start = next_phys;
      if ($urandom_range(0, 7) == 0)
        d.phys_start = next_phys + (64'($urandom_range(1, 16)) << PAGE_SHIFT);
      d.virt_start = rand64();
      d.page_count = pick_pages();
      d.end_of_map = (i == len - 1) ? !broken : ($urandom_range(0, 49) == 0);
      next_phys = d.phys_start + (64'(d.page_count) << PAGE_SHIFT);
      drive_item(d);
    end
  endtask

  task automatic send_noise();
    drive_item(mk($urandom, rand64(), rand64(), 52'(rand64()), rand64(),
                  1'($urandom)));
  endtask

  task automatic directed();
    logic [63:0] sat_end;
    sat_end = 64'h1000 + (64'(mmac_pkg::PAGES_MAX) << PAGE_SHIFT);
    // zero attributes on code, then merges with implicit and explicit read-only
    drive_item(mk(32'd5, 64'h10000, 64'hA000, 52'd4, 64'h0, 1'b0));
    drive_item(mk(32'd5, 64'h14000, 64'hB000, 52'd2, 64'h0, 1'b0));
    drive_item(mk(32'd5, 64'h16000, 64'h0, 52'd1, mmac_pkg::RST_READONLY_MASK, 1'b0));
    // data region gets no-execute, zero page count merges too
    drive_item(mk(32'd7, 64'h17000, 64'hC000, 52'd3, 64'h0, 1'b0));
    drive_item(mk(32'd7, 64'h1A000, 64'h0, 52'd0, mmac_pkg::RST_NOEXEC_MASK, 1'b0));
    drive_item(mk(32'd7, 64'h1A000, 64'h0, 52'd5, 64'h0, 1'b0));
    drive_item(mk(32'd7, 64'h1F000, 64'h0, 52'd1, mmac_pkg::RST_NOEXEC_MASK, 1'b1));
    // end of map with nothing open
    drive_item(mk(32'd3, 64'h0, 64'h1, 52'd1, 64'h1, 1'b1));
    // page sum saturation
    drive_item(mk(32'd3, 64'h1000, 64'h0, mmac_pkg::PAGES_MAX, 64'h1, 1'b0));
    drive_item(mk(32'd3, sat_end, 64'h0, 52'd2, 64'h1, 1'b0));
    drive_item(mk(32'd3, sat_end, 64'h0, 52'd7, 64'h1, 1'b0));
    // end address wraps past the top of the address space
    drive_item(mk(32'd4, 64'hFFFF_FFFF_FFFF_F000, '1, 52'd2, 64'h2, 1'b0));
    drive_item(mk(32'd4, 64'h1000, 64'h0, 52'd3, 64'h2, 1'b1));
    // all ones and all zeros
    drive_item(mk('1, '1, '1, mmac_pkg::PAGES_MAX, '1, 1'b0));
    drive_item(mk('1, '1, '1, 52'd1, '1, 1'b1));
    drive_item(mk('0, '0, '0, '0, '0, 1'b0));
    drive_item(mk('0, '0, '0, '0, mmac_pkg::RST_NOEXEC_MASK, 1'b0));
    // type change and attribute change break a run
    drive_item(mk(32'd5, '0, '0, 52'd1, '0, 1'b1));
    drive_item(mk(32'd5, 64'h5000, 64'h0, 52'd1, 64'h0, 1'b0));
    drive_item(mk(32'd5, 64'h6000, 64'h0, 52'd1, mmac_pkg::RST_NOEXEC_MASK, 1'b1));
  endtask

  initial begin
    int sent_mark;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_index = mmac_pkg::CFG_CODE_TYPE;
    cfg_wdata = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed();
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: configure('0, '0, '0);
        1: configure('1, '1, '1);
        3: configure(32'd7, 64'h8, mmac_pkg::RST_READONLY_MASK);
        5: configure(mmac_pkg::RST_CODE_TYPE, mmac_pkg::RST_READONLY_MASK,
                     mmac_pkg::RST_NOEXEC_MASK);
        default: configure(32'($urandom_range(0, 9)), rand64(), rand64());
      endcase
      calm = (p == 2);
      // long receiver hold-off while items keep coming
      if (p == 3) backlog_req = 1'b1;
      sent_mark = sb.n_in;
      while (sb.n_in - sent_mark < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) != 0) begin
          send_map($urandom_range(2, 12), $urandom_range(0, 9) == 0);
        end else begin
          repeat ($urandom_range(1, 3)) send_noise();
        end
      end
      settle();
    end
    calm = 1'b0;

    $display("Checked %0d coalesced descriptors from %0d input descriptors under %0d settings.",
             sb.n_out, sb.n_in, n_cfg + 1);
    $display("Runs merged %0d times (%0d saturated), %0d end-of-map flushes.",
             sb.n_merge, sb.n_sat, sb.n_flush);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
